// ===== src/cdq_pkg.sv =====
package cdq_pkg;

  localparam int FUNC_W   = 3;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 8;

  // request codes
  localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_PEEK_FRONT = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_PEEK_BACK  = 3'd5;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

  // per-cycle command broadcast to every cell
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT_UP,    // take left neighbor (push front)
    CELL_SHIFT_DOWN,  // take right neighbor (pop front)
    CELL_WRITE_BACK   // first free cell takes the pushed word
  } cell_op_t;

endpackage

// ===== src/cdq_if.sv =====
interface cdq_in_if;
  import cdq_pkg::*;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [WORD_W-1:0] data_in;

  modport source (output valid, output func, output data_in, input ready);
  modport sink   (input valid, input func, input data_in, output ready);
endinterface

interface cdq_out_if;
  import cdq_pkg::*;
  logic                valid;
  logic                ready;
  logic [WORD_W-1:0]   data_out;
  logic [STATUS_W-1:0] status;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, output data_out, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input data_out, input status, input occupancy,
                  output ready);
endinterface

// ===== src/cdq_cell.sv =====
module cdq_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int CW         = 8,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  cdq_pkg::cell_op_t     op,
  input  logic [CW-1:0]         cnt,
  input  logic [DATA_WIDTH-1:0] word,
  input  logic [DATA_WIDTH-1:0] left_q,
  input  logic [DATA_WIDTH-1:0] right_q,
  output logic [DATA_WIDTH-1:0] q,
  output logic [DATA_WIDTH-1:0] tap
);
  import cdq_pkg::*;

  localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
  localparam logic [CW-1:0] MY_NEXT = CW'(IDX + 1);

  logic [DATA_WIDTH-1:0] data_r, data_nxt;

  always_comb begin
    case (op)
      CELL_SHIFT_UP:   data_nxt = left_q;
      CELL_SHIFT_DOWN: data_nxt = right_q;
      CELL_WRITE_BACK: data_nxt = (cnt == MY_IDX) ? word : data_r;
      default:         data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q   = data_r;
  // only the back cell drives the gather tree
  assign tap = (cnt == MY_NEXT) ? data_r : '0;

endmodule

// ===== src/cdq_or_tree.sv =====
module cdq_or_tree #(
  parameter int DEPTH      = 128,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic [DATA_WIDTH-1:0] tap [DEPTH],
  output logic [DATA_WIDTH-1:0] root
);

  localparam int LV = $clog2(DEPTH);
  localparam int P  = 1 << LV;

  // heap order: internal nodes 0..P-2 registered, leaves P-1..2P-2
  logic [DATA_WIDTH-1:0] node_r   [P-1];
  logic [DATA_WIDTH-1:0] node_nxt [P-1];
  logic [DATA_WIDTH-1:0] heap_w   [2*P-1];

  always_comb begin
    for (int i = 0; i < P - 1; i++) begin
      heap_w[i] = node_r[i];
    end
    for (int j = 0; j < P; j++) begin
      heap_w[P-1+j] = (j < DEPTH) ? tap[j] : '0;
    end
    for (int i = 0; i < P - 1; i++) begin
      node_nxt[i] = heap_w[2*i+1] | heap_w[2*i+2];
    end
  end

  always_ff @(posedge clk) begin
    node_r <= node_nxt;
  end

  assign root = node_r[0];

endmodule

// ===== src/circular_deque_unit.sv =====
// Channel  Port    Dir  Word
// -------  ------  ---  ---------------------------------------------
// input    in_ch   in   func[2:0], data_in[31:0]
// result   out_ch  out  data_out[31:0], status[1:0], occupancy[7:0]
//
// A new request is not taken until the tree has settled on the last one: the back word
// comes out of a registered OR tree over the cells, and after every request
// in_ch.ready stays low while the tree settles on the new contents.
// Reset (rst_n, synchronous, low) clears count and output valid and holds
// in_ch.ready low while the tree settles.
// A result waiting in the output register does not block acceptance when
// out_ch.ready is high in the same cycle; otherwise in_ch.ready stays low.
module circular_deque_unit #(
  parameter int DEPTH      = 128,
  parameter int DATA_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  cdq_in_if.sink     in_ch,
  cdq_out_if.source  out_ch
);
  import cdq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);  // count, 0..DEPTH
  localparam int LV = $clog2(DEPTH);      // tree levels
  localparam int SW = $clog2(LV + 1);

  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
  localparam logic [SW-1:0] SETTLE   = SW'(LV);

  // control state
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] settle_r, settle_nxt;
  logic          out_vld_r, out_vld_nxt;

  // result word registers
  logic [WORD_W-1:0]   data_out_r, data_out_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [OCC_W-1:0]    occ_r, occ_nxt;

  logic                  accept;
  cell_op_t              op_dec, op;
  logic [CW-1:0]         cnt_dec;
  logic [DATA_WIDTH-1:0] rd;
  logic [DATA_WIDTH-1:0] word;
  logic [DATA_WIDTH+31:0] word_ext, rd_ext;
  logic [CW+7:0]         occ_ext;
  logic [DATA_WIDTH-1:0] cell_q [DEPTH];
  logic [DATA_WIDTH-1:0] tap    [DEPTH];
  logic [DATA_WIDTH-1:0] front_q, back_q;

  assign in_ch.ready = (settle_r == '0) && (!out_vld_r || out_ch.ready);
  assign accept      = in_ch.valid && in_ch.ready;

  // keep low DATA_WIDTH bits of the pushed word
  assign word_ext = {{DATA_WIDTH{1'b0}}, in_ch.data_in};
  assign word     = word_ext[DATA_WIDTH-1:0];

  assign front_q = cell_q[0];

  // request decode; back_q is valid whenever ready is high
  always_comb begin
    op_dec     = CELL_HOLD;
    cnt_dec    = cnt_r;
    rd         = '0;
    status_nxt = STATUS_DONE;
    unique case (in_ch.func) inside
      FUNC_PUSH_FRONT, FUNC_PUSH_BACK: begin
        if (cnt_r == CNT_FULL) begin
          status_nxt = STATUS_FULL;
        end else begin
          op_dec  = (in_ch.func == FUNC_PUSH_FRONT) ? CELL_SHIFT_UP : CELL_WRITE_BACK;
          cnt_dec = cnt_r + CW'(1);
        end
      end
      FUNC_POP_FRONT, FUNC_POP_BACK, FUNC_PEEK_FRONT, FUNC_PEEK_BACK: begin
        if (cnt_r == '0) begin
          status_nxt = STATUS_EMPTY;
        end else begin
          if (in_ch.func == FUNC_POP_FRONT || in_ch.func == FUNC_PEEK_FRONT) begin
            rd = front_q;
          end else begin
            rd = back_q;
          end
          if (in_ch.func == FUNC_POP_FRONT) begin
            op_dec  = CELL_SHIFT_DOWN;
            cnt_dec = cnt_r - CW'(1);
          end else if (in_ch.func == FUNC_POP_BACK) begin
            // back pop only moves the count; the cell keeps stale data
            cnt_dec = cnt_r - CW'(1);
          end
        end
      end
      default: ;  // unused codes: no change, status done
    endcase
  end

  assign rd_ext       = {32'b0, rd};
  assign data_out_nxt = rd_ext[31:0];
  assign occ_ext      = {8'b0, cnt_dec};
  assign occ_nxt      = occ_ext[7:0];

  always_comb begin
    op          = accept ? op_dec : CELL_HOLD;
    cnt_nxt     = accept ? cnt_dec : cnt_r;
    out_vld_nxt = accept ? 1'b1 : (out_ch.ready ? 1'b0 : out_vld_r);
    if (accept) begin
      settle_nxt = SETTLE;
    end else if (settle_r != '0) begin
      settle_nxt = settle_r - SW'(1);
    end else begin
      settle_nxt = settle_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      settle_r  <= SETTLE;
      out_vld_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      settle_r  <= settle_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_out_r <= data_out_nxt;
      status_r   <= status_nxt;
      occ_r      <= occ_nxt;
    end
  end

  assign out_ch.valid     = out_vld_r;
  assign out_ch.data_out  = data_out_r;
  assign out_ch.status    = status_r;
  assign out_ch.occupancy = occ_r;

  // cell row: cell 0 is the front, cell cnt-1 the back
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_q, right_q;
    if (i == 0) begin : g_first
      assign left_q = word;
    end else begin : g_mid_l
      assign left_q = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right_q = '0;
    end else begin : g_mid_r
      assign right_q = cell_q[i+1];
    end
    cdq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CW         (CW),
      .IDX        (i)
    ) u_cell (
      .clk     (clk),
      .op      (op),
      .cnt     (cnt_r),
      .word    (word),
      .left_q  (left_q),
      .right_q (right_q),
      .q       (cell_q[i]),
      .tap     (tap[i])
    );
  end

  // gathers the back word
  cdq_or_tree #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_tree (
    .clk  (clk),
    .tap  (tap),
    .root (back_q)
  );

endmodule

// ===== src/cdq_checker.sv =====
module cdq_props #(
  parameter int DEPTH = 128
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [cdq_pkg::WORD_W-1:0]    data_out,
  input logic [cdq_pkg::STATUS_W-1:0]  status,
  input logic [cdq_pkg::OCC_W-1:0]     occupancy
);
  import cdq_pkg::*;

  localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH % 256);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(data_out) && $stable(status)
                                && $stable(occupancy))
    else $error("result word changed while stalled");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != STATUS_DONE |-> data_out == '0)
    else $error("refused request carries data");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == STATUS_FULL |-> occupancy == OCC_FULL)
    else $error("full refusal with wrong occupancy");

  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == STATUS_EMPTY |-> occupancy == '0)
    else $error("empty refusal with nonzero occupancy");

  a_settle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken before back word settled");

endmodule

bind circular_deque_unit cdq_props #(.DEPTH(DEPTH)) u_cdq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .data_out  (out_ch.data_out),
  .status    (out_ch.status),
  .occupancy (out_ch.occupancy)
);
